@@ src/kcbe_pkg.sv @@
// Shared types and constants for the count block encoder.
// Used by kcbe_chunker, kcbe_outbuf, the top level and the checker.
package kcbe_pkg;

  // count bits taken from mer_count
  localparam int CountWidth = 32;
  // width of the check_width register
  localparam int CwBits     = 6;
  // block value width and block width field width
  localparam int BlockBits  = 64;
  localparam int WidthBits  = 7;
  // check_width after reset
  localparam logic [CwBits-1:0] CwReset = 6'd16;

  // one block on its way to the output register
  typedef struct packed {
    logic                 valid;
    logic [BlockBits-1:0] bits;
    logic [WidthBits-1:0] width;
    logic                 last;
  } blk_t;

  // zero check width counts as one
  function automatic logic [CwBits-1:0] eff_width(input logic [CwBits-1:0] cw);
    logic [CwBits-1:0] w;
    w = (cw == '0) ? CwBits'(1) : cw;
    return w;
  endfunction

endpackage

@@ src/kcbe_chunker.sv @@
// Record sequencer: emits the check block, then moves the count out one bit
// per cycle into chunks, pausing while a chunk waits. Depends on kcbe_pkg.
module kcbe_chunker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [kcbe_pkg::BlockBits-1:0]  check_word,
  input  logic [31:0]                     mer_count,
  input  logic [kcbe_pkg::CwBits-1:0]     width,
  output kcbe_pkg::blk_t                  blk_o,
  input  logic                            blk_ready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HEAD  = 3'd1;
  localparam logic [2:0] S_ZERO  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_FULL  = 3'd4;

  logic [2:0]                          state;
  logic [kcbe_pkg::BlockBits-1:0]      chk;
  logic [kcbe_pkg::CountWidth-1:0]     cnt;
  logic [kcbe_pkg::CwBits-1:0]         w;
  logic [kcbe_pkg::CwBits-1:0]         pos;
  logic [kcbe_pkg::BlockBits-1:0]      blk;
  logic                                lastr;

  logic [kcbe_pkg::BlockBits-1:0]      flag;
  logic [kcbe_pkg::BlockBits-1:0]      mask;
  logic [kcbe_pkg::CountWidth-1:0]     cnt_rest;
  logic                                rest_zero;
  logic                                cnt_one;
  logic                                cnt_zero;
  logic                                chunk_end;
  logic [kcbe_pkg::BlockBits-1:0]      blk_next;
  logic                                push;

  // flag bit sits just above the chunk
  assign flag      = kcbe_pkg::BlockBits'(1) << w;
  assign mask      = flag - kcbe_pkg::BlockBits'(1);
  assign cnt_rest  = cnt >> 1;
  assign rest_zero = (cnt_rest == '0);
  assign cnt_one   = (cnt == kcbe_pkg::CountWidth'(1));
  assign cnt_zero  = (cnt == '0);
  assign chunk_end = (pos == (w - kcbe_pkg::CwBits'(1))) || rest_zero;

  // place the next count bit, and the flag when the count runs out
  assign blk_next = blk
                  | (kcbe_pkg::BlockBits'(cnt[0]) << pos)
                  | ((chunk_end && rest_zero) ? flag : '0);

  assign in_stall = (state != S_IDLE);
  assign push     = blk_o.valid && blk_ready;

  // block offered to the output register
  always_comb begin
    blk_o.valid = 1'b0;
    blk_o.bits  = blk;
    blk_o.width = {1'b0, w} + kcbe_pkg::WidthBits'(1);
    blk_o.last  = lastr;
    case (state)
      S_HEAD: begin
        blk_o.valid = 1'b1;
        blk_o.bits  = (chk & mask) | (cnt_one ? flag : '0);
        blk_o.last  = cnt_one;
      end
      S_ZERO: begin
        blk_o.valid = 1'b1;
        blk_o.bits  = flag;
        blk_o.last  = 1'b1;
      end
      S_FULL: begin
        blk_o.valid = 1'b1;
      end
      default: begin
        blk_o.valid = 1'b0;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_HEAD;
        end
        S_HEAD: begin
          if (push) begin
            if (cnt_one)       state <= S_IDLE;
            else if (cnt_zero) state <= S_ZERO;
            else               state <= S_SHIFT;
          end
        end
        S_ZERO: begin
          if (push) state <= S_IDLE;
        end
        S_SHIFT: begin
          if (chunk_end) state <= S_FULL;
        end
        S_FULL: begin
          if (push) state <= lastr ? S_IDLE : S_SHIFT;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath: count shifts right one bit per cycle while in S_SHIFT
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        chk <= check_word;
        cnt <= mer_count[kcbe_pkg::CountWidth-1:0];
        w   <= width;
        pos <= '0;
        blk <= '0;
      end
      S_SHIFT: begin
        blk   <= blk_next;
        cnt   <= cnt_rest;
        pos   <= pos + kcbe_pkg::CwBits'(1);
        lastr <= rest_zero;
      end
      S_FULL: begin
        if (push) begin
          blk <= '0;
          pos <= '0;
        end
      end
      default: begin
        pos <= pos;
      end
    endcase
  end

endmodule

@@ src/kcbe_outbuf.sv @@
// Output register between the sequencer and the result channel.
// Depends on kcbe_pkg.
module kcbe_outbuf (
  input  logic                            clk,
  input  logic                            rst,
  input  kcbe_pkg::blk_t                  blk_i,
  output logic                            blk_ready,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [kcbe_pkg::BlockBits-1:0]  block_bits,
  output logic [kcbe_pkg::WidthBits-1:0]  block_width,
  output logic                            last_block
);

  logic                            valid;
  logic [kcbe_pkg::BlockBits-1:0]  bits;
  logic [kcbe_pkg::WidthBits-1:0]  wid;
  logic                            last;

  // free when empty or when the held item leaves this cycle
  assign blk_ready = !valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (blk_ready) begin
      valid <= blk_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_ready && blk_i.valid) begin
      bits <= blk_i.bits;
      wid  <= blk_i.width;
      last <= blk_i.last;
    end
  end

  assign out_valid   = valid;
  assign block_bits  = bits;
  assign block_width = wid;
  assign last_block  = last;

endmodule

@@ src/kmer_count_block_encoder.sv @@
// Top level of the count block encoder: check_width register, sequencer and
// output register. Depends on kcbe_pkg, kcbe_chunker and kcbe_outbuf.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------
//   input    | in_valid / in_stall    | check_word, mer_count
//   result   | out_valid / out_stall  | block_bits, block_width, last_block
//   config   | cfg_valid / cfg_ready  | cfg_data (check_width)
//
// One record at a time. After it is taken, the sequencer offers the check
// block in the next cycle; a count of 1 needs one block, a count of 0 two.
// A larger count moves out of its shift register one bit per cycle up to its
// highest set bit, pausing while each full chunk is handed over, then goes idle.
// Reset (rst, synchronous) empties the pipeline and sets check_width to 16.
// A stalled result holds its block and the sequencer waits behind it.
module kmer_count_block_encoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [kcbe_pkg::BlockBits-1:0]  check_word,
  input  logic [31:0]                     mer_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [kcbe_pkg::BlockBits-1:0]  block_bits,
  output logic [kcbe_pkg::WidthBits-1:0]  block_width,
  output logic                            last_block,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kcbe_pkg::CwBits-1:0]     cfg_data
);

  logic [kcbe_pkg::CwBits-1:0] check_width;
  kcbe_pkg::blk_t              blk;
  logic                        blk_ready;

  // check_width register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_width <= kcbe_pkg::CwReset;
    end else if (cfg_valid) begin
      check_width <= cfg_data;
    end
  end

  kcbe_chunker u_chunker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .check_word (check_word),
    .mer_count  (mer_count),
    .width      (kcbe_pkg::eff_width(check_width)),
    .blk_o      (blk),
    .blk_ready  (blk_ready)
  );

  kcbe_outbuf u_outbuf (
    .clk         (clk),
    .rst         (rst),
    .blk_i       (blk),
    .blk_ready   (blk_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .block_bits  (block_bits),
    .block_width (block_width),
    .last_block  (last_block)
  );

endmodule

@@ src/kcbe_checker.sv @@
// Port-level checks for the count block encoder, bound to the top level.
// Depends on kmer_count_block_encoder ports only.
module kcbe_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] block_bits,
  input logic [6:0]  block_width,
  input logic        last_block
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(block_bits)
                                  && $stable(last_block)))
    else $error("stalled result changed");

  // one record at a time: busy right after an item is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a record is in flight");

  // no bits above the block width
  a_bits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((block_bits >> block_width) == 64'd0))
    else $error("block bits beyond block width");

  // width lies in the range of check width plus one, from 2 to 64
  a_width: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (block_width >= 7'd2 && block_width <= 7'd64))
    else $error("block width out of range");

endmodule

bind kmer_count_block_encoder kcbe_checker u_kcbe_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .block_bits  (block_bits),
  .block_width (block_width),
  .last_block  (last_block)
);

@@ tb/sv/kcbe_checker.sv @@
// Checker for the count block encoder: watches the config, input and result
// channels, predicts the blocks of each record and compares them in order.
// Depends on kcbe_pkg for port widths and the check_width reset value.
module kcbe_scoreboard (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [kcbe_pkg::BlockBits-1:0]  check_word,
  input  logic [31:0]                     mer_count,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [kcbe_pkg::BlockBits-1:0]  block_bits,
  input  logic [kcbe_pkg::WidthBits-1:0]  block_width,
  input  logic                            last_block,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [kcbe_pkg::CwBits-1:0]     cfg_data,
  output int                              errors,
  output int                              pending
);

  typedef struct packed {
    logic [kcbe_pkg::BlockBits-1:0] bits;
    logic [kcbe_pkg::WidthBits-1:0] width;
    logic                           last;
  } block_t;

  block_t                      blocks_due[$];
  logic [kcbe_pkg::CwBits-1:0] chunk_width;

  // split one record into its check block and count chunks
  function automatic void encode_record(input logic [63:0] chk_in, input logic [31:0] cnt);
    int unsigned w;
    logic [63:0] mask;
    logic [63:0] flag;
    logic [63:0] q;
    logic [63:0] v;
    block_t      b;
    w = (chunk_width == '0) ? 1 : chunk_width;
    mask = (64'd1 << w) - 64'd1;
    flag = 64'd1 << w;
    q = {32'd0, cnt};
    b.width = kcbe_pkg::WidthBits'(w + 1);
    // count of one rides on the check block
    if (q == 64'd1) begin
      b.bits = (chk_in & mask) | flag;
      b.last = 1'b1;
      blocks_due.push_back(b);
      return;
    end
    b.bits = chk_in & mask;
    b.last = 1'b0;
    blocks_due.push_back(b);
    // count of zero is a lone flag chunk
    if (q == 64'd0) begin
      b.bits = flag;
      b.last = 1'b1;
      blocks_due.push_back(b);
      return;
    end
    // least significant chunk first, flag on the final one
    while (q != 64'd0) begin
      v = q & mask;
      q = q >> w;
      b.last = (q == 64'd0);
      if (b.last) v = v | flag;
      b.bits = v;
      blocks_due.push_back(b);
    end
  endfunction

  // follow the channels at each rising edge
  always @(posedge clk) begin
    block_t exp_blk;
    if (rst) begin
      chunk_width = kcbe_pkg::CwReset;
      blocks_due.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) chunk_width = cfg_data;
      // compare each result item with the oldest prediction
      if (out_valid && !out_stall) begin
        if (blocks_due.size() == 0) begin
          $display("%0t: unexpected block bits=%h width=%0d last=%0b",
                   $time, block_bits, block_width, last_block);
          errors = errors + 1;
        end else begin
          exp_blk = blocks_due.pop_front();
          if (block_bits !== exp_blk.bits) begin
            $display("%0t: block_bits expected %h actual %h", $time, exp_blk.bits, block_bits);
            errors = errors + 1;
          end
          if (block_width !== exp_blk.width) begin
            $display("%0t: block_width expected %0d actual %0d",
                     $time, exp_blk.width, block_width);
            errors = errors + 1;
          end
          if (last_block !== exp_blk.last) begin
            $display("%0t: last_block expected %0b actual %0b", $time, exp_blk.last, last_block);
            errors = errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) encode_record(check_word, mer_count);
    end
    pending = blocks_due.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    chunk_width = kcbe_pkg::CwReset;
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the count block encoder: clock, reset, record and config
// stimulus, result stalls and the verdict. Depends on kcbe_pkg and kcbe_scoreboard.
module tb;

  localparam int CycleLimit = 400000;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic [kcbe_pkg::BlockBits-1:0]  check_word;
  logic [31:0]                     mer_count;
  logic                            out_valid;
  logic                            out_stall;
  logic [kcbe_pkg::BlockBits-1:0]  block_bits;
  logic [kcbe_pkg::WidthBits-1:0]  block_width;
  logic                            last_block;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [kcbe_pkg::CwBits-1:0]     cfg_data;
  int                              errors;
  int                              pending;
  int                              cycles;
  logic                            calm;
  logic                            squeeze;

  kmer_count_block_encoder dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .check_word  (check_word),
    .mer_count   (mer_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .block_bits  (block_bits),
    .block_width (block_width),
    .last_block  (last_block),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  kcbe_scoreboard u_scoreboard (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .check_word  (check_word),
    .mer_count   (mer_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .block_bits  (block_bits),
    .block_width (block_width),
    .last_block  (last_block),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .pending     (pending)
  );

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side stalls: random, one long hold-off, none while calm
  initial begin
    int hold_left;
    logic held;
    hold_left = 0;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze && !held) begin
        held = 1'b1;
        hold_left = 300;
      end
      out_stall <= (hold_left > 0) || (!calm && $urandom_range(99) < 6);
      if (hold_left > 0) hold_left = hold_left - 1;
    end
  end

  // offer one record and wait for it to be taken
  task automatic send_record(input logic [63:0] chk_in, input logic [31:0] cnt);
    int gap;
    if (!calm && $urandom_range(99) < 6) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    check_word <= chk_in;
    mer_count  <= cnt;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // let every predicted block come out, then a few spare cycles
  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // write check_width while the block is idle
  task automatic set_width(input logic [kcbe_pkg::CwBits-1:0] w);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random count with a spread of magnitudes
  function automatic logic [31:0] rand_count;
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      default: return $urandom >> $urandom_range(31, 0);
    endcase
  endfunction

  // stimulus and verdict
  initial begin
    logic [kcbe_pkg::CwBits-1:0] phase_width[6];
    rst        = 1'b1;
    in_valid   = 1'b0;
    check_word = '0;
    mer_count  = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    calm       = 1'b0;
    squeeze    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset width of 16
    send_record(64'd0, 32'd0);
    send_record({64{1'b1}}, 32'd0);
    send_record({64{1'b1}}, 32'd1);
    send_record(64'd0, 32'd1);
    send_record(64'h0123_4567_89AB_CDEF, 32'd2);
    send_record({64{1'b1}}, 32'hFFFF_FFFF);
    send_record(64'hFEDC_BA98_7654_3210, 32'd65535);
    send_record(64'h5555_5555_5555_5555, 32'd65536);
    send_record(64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
    // zero width acts as one: widest run of chunks
    set_width('0);
    send_record({64{1'b1}}, 32'hFFFF_FFFF);
    send_record({64{1'b1}}, 32'd1);
    send_record(64'd0, 32'd0);
    // widest chunk
    set_width(6'd63);
    send_record({64{1'b1}}, 32'hFFFF_FFFF);
    send_record(64'h8000_0000_0000_0000, 32'd1);
    send_record(64'd0, 32'd0);
    send_record(64'd5, 32'd2);
    // narrowest legal chunk
    set_width(6'd1);
    send_record(64'd1, 32'h8000_0000);
    send_record(64'd0, 32'd3);

    // random phases over several widths
    phase_width[0] = 6'd32;
    phase_width[1] = 6'd63;
    phase_width[2] = 6'd1;
    phase_width[3] = 6'($urandom_range(2, 62));
    phase_width[4] = 6'd0;
    phase_width[5] = 6'd16;
    for (int p = 0; p < 6; p++) begin
      set_width(phase_width[p]);
      calm <= (p == 3);
      for (int i = 0; i < 50; i++) begin
        if (p == 1 && i == 5) squeeze <= 1'b1;
        send_record({$urandom, $urandom}, rand_count());
      end
    end
    calm <= 1'b0;
    drain();
    repeat (20) @(negedge clk);

    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
